// ----- rtl/core/aht_pkg.sv -----
package aht_pkg;

  localparam int DEF_MAX_READERS = 16;
  localparam int DEF_NODE_BITS   = 16;

  localparam int CMD_W  = 2;
  localparam int KIND_W = 3;
  localparam int ID_W   = 16;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;

  localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RAW  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WAR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WAW  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BAD  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OVF  = 3'd5;

endpackage

// ----- rtl/core/access_hazard_tracker_unit.sv -----
// Hazard tracker for one data object. Each input item is one access (tuser: read, write
// or invalid; tdata: the accessing node) and yields one or more dependency items, the
// final one marked by tlast. Readers since the last write sit in a reader memory with
// separate write and read ports; a write walks it one entry per cycle unless the output
// stalls. An item passes the states head, walk (only for a write with stored readers),
// tail and fin. A new item is taken once the previous one has handed its last result
// to the output register.
module access_hazard_tracker_unit #(
  parameter int MAX_READERS = aht_pkg::DEF_MAX_READERS,
  parameter int NODE_BITS   = aht_pkg::DEF_NODE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,   // object_id
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,     // [15:0] kernel_node
  input  logic [1:0]  s_tuser,     // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,     // [15:0] consumer_node, [31:16] producer_node,
                                   // [47:32] dep_object
  output logic [2:0]  m_tuser,     // [2:0] dep_kind
  output logic        m_tlast
);

  localparam int CW = $clog2(MAX_READERS + 1);
  localparam int IW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;

  logic [aht_pkg::ID_W-1:0] object_id;
  logic [NODE_BITS-1:0]     node_in;
  logic                     mem_we;
  logic [IW-1:0]            mem_waddr;
  logic [NODE_BITS-1:0]     mem_wdata;
  logic                     mem_re;
  logic [IW-1:0]            mem_raddr;
  logic [NODE_BITS-1:0]     mem_rdata;
  logic [NODE_BITS-1:0]     out_cons;
  logic [NODE_BITS-1:0]     out_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      object_id <= '0;
    end else if (cfg_we) begin
      object_id <= cfg_wdata;
    end
  end

  assign node_in = NODE_BITS'(s_tdata);

  aht_reader_mem #(
    .DEPTH (MAX_READERS),
    .WIDTH (NODE_BITS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  aht_seq #(
    .MAX_READERS (MAX_READERS),
    .NODE_BITS   (NODE_BITS),
    .CW          (CW),
    .IW          (IW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_node   (node_in),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_kind  (m_tuser),
    .out_cons  (out_cons),
    .out_prod  (out_prod),
    .out_last  (m_tlast)
  );

  assign m_tdata = {object_id, 16'(out_prod), 16'(out_cons)};

endmodule

// ----- rtl/core/aht_reader_mem.sv -----
module aht_reader_mem #(
  parameter int DEPTH = aht_pkg::DEF_MAX_READERS,
  parameter int WIDTH = aht_pkg::DEF_NODE_BITS,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/aht_seq.sv -----
module aht_seq #(
  parameter int MAX_READERS = aht_pkg::DEF_MAX_READERS,
  parameter int NODE_BITS   = aht_pkg::DEF_NODE_BITS,
  parameter int CW          = $clog2(MAX_READERS + 1),
  parameter int IW          = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [aht_pkg::CMD_W-1:0]  in_cmd,
  input  logic [NODE_BITS-1:0]       in_node,
  output logic                       mem_we,
  output logic [IW-1:0]              mem_waddr,
  output logic [NODE_BITS-1:0]       mem_wdata,
  output logic                       mem_re,
  output logic [IW-1:0]              mem_raddr,
  input  logic [NODE_BITS-1:0]       mem_rdata,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [aht_pkg::KIND_W-1:0] out_kind,
  output logic [NODE_BITS-1:0]       out_cons,
  output logic [NODE_BITS-1:0]       out_prod,
  output logic                       out_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HEAD = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_TAIL = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [CW-1:0] FULL = CW'(MAX_READERS);

  logic [2:0]                   state;
  logic [2:0]                   state_next;
  logic [aht_pkg::CMD_W-1:0]    cur_cmd;
  logic [NODE_BITS-1:0]         cur_node;
  logic                         writer_valid;
  logic [NODE_BITS-1:0]         writer_node;
  logic [CW-1:0]                reader_count;
  logic                         head_hit;
  logic [NODE_BITS-1:0]         head_prod;
  logic [CW-1:0]                walk_cnt;
  logic                         ovf;
  logic [CW-1:0]                issue_idx;
  logic                         have;
  logic                         pend_valid;
  logic [aht_pkg::KIND_W-1:0]   pend_kind;
  logic [NODE_BITS-1:0]         pend_prod;

  logic                         accept;
  logic                         out_free;
  logic                         gen_ready;
  logic                         is_read;
  logic                         is_write;
  logic                         match;
  logic                         consume;
  logic                         issue;
  logic                         tail_hit;
  logic                         gen_valid;
  logic [aht_pkg::KIND_W-1:0]   gen_kind;
  logic [NODE_BITS-1:0]         gen_prod;
  logic                         gen_take;
  logic                         push_pend;
  logic                         fin_push;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign gen_ready = !pend_valid || out_free;
  assign is_read   = (cur_cmd == aht_pkg::CMD_READ);
  assign is_write  = (cur_cmd == aht_pkg::CMD_WRITE);
  assign match     = (mem_rdata == cur_node);
  assign consume   = (state == ST_WALK) && have && (match || gen_ready);
  assign issue     = is_write && ((state == ST_HEAD) || (state == ST_WALK)) &&
                     (!have || consume) && (issue_idx != walk_cnt);
  assign tail_hit  = (is_read && ovf) || (!is_read && !is_write);

  assign mem_we    = accept && (in_cmd == aht_pkg::CMD_READ) && (reader_count != FULL);
  assign mem_waddr = reader_count[IW-1:0];
  assign mem_wdata = in_node;
  assign mem_re    = issue;
  assign mem_raddr = issue_idx[IW-1:0];

  always_comb begin
    gen_valid = 1'b0;
    gen_kind  = aht_pkg::KIND_NONE;
    gen_prod  = '0;
    unique case (state)
      ST_HEAD: begin
        gen_valid = head_hit;
        gen_kind  = is_read ? aht_pkg::KIND_RAW : aht_pkg::KIND_WAW;
        gen_prod  = head_prod;
      end
      ST_WALK: begin
        gen_valid = have && !match;
        gen_kind  = aht_pkg::KIND_WAR;
        gen_prod  = mem_rdata;
      end
      ST_TAIL: begin
        gen_valid = tail_hit;
        gen_kind  = is_read ? aht_pkg::KIND_OVF : aht_pkg::KIND_BAD;
      end
      default: begin
        gen_valid = 1'b0;
      end
    endcase
  end

  assign gen_take  = gen_valid && gen_ready;
  assign push_pend = gen_take && pend_valid;
  assign fin_push  = (state == ST_FIN) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HEAD;
      end
      ST_HEAD: begin
        if (!head_hit || gen_ready) begin
          state_next = (is_write && (walk_cnt != '0)) ? ST_WALK : ST_TAIL;
        end
      end
      ST_WALK: begin
        if ((issue_idx == walk_cnt) && (!have || consume)) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        if (!tail_hit || gen_ready) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      writer_valid <= 1'b0;
      writer_node  <= '0;
      reader_count <= '0;
      have         <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        if (in_cmd == aht_pkg::CMD_READ) begin
          if (reader_count != FULL) reader_count <= reader_count + 1'b1;
        end else if (in_cmd == aht_pkg::CMD_WRITE) begin
          reader_count <= '0;
          writer_node  <= in_node;
          writer_valid <= 1'b1;
        end
      end

      if (issue) begin
        have <= 1'b1;
      end else if (consume) begin
        have <= 1'b0;
      end

      if (gen_take) begin
        pend_valid <= 1'b1;
      end else if (fin_push) begin
        pend_valid <= 1'b0;
      end

      if (push_pend || fin_push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd   <= in_cmd;
      cur_node  <= in_node;
      head_hit  <= writer_valid && (writer_node != in_node) &&
                   ((in_cmd == aht_pkg::CMD_READ) || (in_cmd == aht_pkg::CMD_WRITE));
      head_prod <= writer_node;
      walk_cnt  <= reader_count;
      ovf       <= (reader_count == FULL);
      issue_idx <= '0;
    end else if (issue) begin
      issue_idx <= issue_idx + 1'b1;
    end

    if (gen_take) begin
      pend_kind <= gen_kind;
      pend_prod <= gen_prod;
    end

    if (push_pend) begin
      out_kind <= pend_kind;
      out_prod <= pend_prod;
      out_cons <= cur_node;
      out_last <= 1'b0;
    end else if (fin_push) begin
      out_kind <= pend_valid ? pend_kind : aht_pkg::KIND_NONE;
      out_prod <= pend_valid ? pend_prod : '0;
      out_cons <= cur_node;
      out_last <= 1'b1;
    end
  end

endmodule

// ----- rtl/core/aht_checker.sv -----
module aht_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("output item changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is still in work");

  a_no_producer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == aht_pkg::KIND_NONE) || (m_tuser == aht_pkg::KIND_BAD) ||
    (m_tuser == aht_pkg::KIND_OVF)) |-> (m_tdata[31:16] == 16'd0))
    else $error("producer set on a result without dependency");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == aht_pkg::KIND_NONE) || (m_tuser == aht_pkg::KIND_BAD)) |->
    m_tlast)
    else $error("none or bad access result not final");

  a_no_self_dep: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == aht_pkg::KIND_RAW) || (m_tuser == aht_pkg::KIND_WAR) ||
    (m_tuser == aht_pkg::KIND_WAW)) |-> (m_tdata[15:0] != m_tdata[31:16]))
    else $error("dependency of a node on itself");

endmodule

bind access_hazard_tracker_unit aht_checker u_aht_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam logic [aht_pkg::CMD_W-1:0] CMD_NONE  = 2'd2;
  localparam logic [aht_pkg::CMD_W-1:0] CMD_UNDEF = 2'd3;
  localparam int READER_SLOTS = aht_pkg::DEF_MAX_READERS;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 800000;

  typedef struct packed {
    logic [aht_pkg::CMD_W-1:0] cmd;
    logic [15:0]               node;
  } access_t;

  typedef struct packed {
    logic [aht_pkg::KIND_W-1:0] kind;
    logic [15:0]                consumer;
    logic [15:0]                producer;
    logic [aht_pkg::ID_W-1:0]   object;
    logic                       last;
  } hazard_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;
  logic [1:0]  s_tuser = 2'b00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  access_t     accesses_pending[$];
  hazard_t     hazards_expected[$];
  access_t     offered;

  logic [aht_pkg::ID_W-1:0] object_model = '0;
  logic            writer_known = 1'b0;
  logic [15:0]     writer_id = '0;
  logic [15:0]     readers[$];
  logic [15:0]     node_pool[4];

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_taken;
  int          tx_gap;
  int          rx_stall;
  int          mismatches = 0;
  int unsigned cycles = 0;

  access_hazard_tracker_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap(bit enable);
    int roll;
    roll = $urandom_range(0, 99);
    if (!enable || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic hazard_t make_hazard(logic [aht_pkg::KIND_W-1:0] kind,
                                          logic [15:0] cons, logic [15:0] prod);
    hazard_t h;
    h.kind = kind;
    h.consumer = cons;
    h.producer = prod;
    h.object = object_model;
    h.last = 1'b0;
    return h;
  endfunction

  task automatic track_access(access_t a);
    hazard_t found[$];
    case (a.cmd)
      aht_pkg::CMD_READ: begin
        if (writer_known && writer_id != a.node)
          found.insert(found.size(), make_hazard(aht_pkg::KIND_RAW, a.node, writer_id));
        if (readers.size() < READER_SLOTS) readers.insert(readers.size(), a.node);
        else found.insert(found.size(), make_hazard(aht_pkg::KIND_OVF, a.node, 16'h0000));
      end
      aht_pkg::CMD_WRITE: begin
        if (writer_known && writer_id != a.node)
          found.insert(found.size(), make_hazard(aht_pkg::KIND_WAW, a.node, writer_id));
        foreach (readers[i])
          if (readers[i] != a.node)
            found.insert(found.size(), make_hazard(aht_pkg::KIND_WAR, a.node, readers[i]));
        readers.delete();
        writer_id = a.node;
        writer_known = 1'b1;
      end
      default: found.insert(found.size(), make_hazard(aht_pkg::KIND_BAD, a.node, 16'h0000));
    endcase
    if (found.size() == 0)
      found.insert(found.size(), make_hazard(aht_pkg::KIND_NONE, a.node, 16'h0000));
    found[found.size()-1].last = 1'b1;
    foreach (found[i]) hazards_expected.insert(hazards_expected.size(), found[i]);
  endtask

  task automatic check_hazard();
    hazard_t seen;
    hazard_t want;
    seen = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast};
    if (hazards_expected.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected item: kind %0d cons %h prod %h obj %h last %b",
                 seen.kind, seen.consumer, seen.producer, seen.object, seen.last);
    end else begin
      want = hazards_expected.pop_front();
      if (seen !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want kind %0d cons %h prod %h obj %h last %b,",
                   want.kind, want.consumer, want.producer, want.object, want.last,
                   " got kind %0d cons %h prod %h obj %h last %b",
                   seen.kind, seen.consumer, seen.producer, seen.object, seen.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) track_access(offered);
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          s_tvalid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (accesses_pending.size() != 0) begin
          offered = accesses_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= offered.node;
          s_tuser <= offered.cmd;
          tx_gap <= pick_gap(tx_idle_on);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
      hold_taken <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_hazard();
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        m_tready <= 1'b0;
        rx_stall <= LONG_HOLD;
      end else if (rx_stall != 0) begin
        m_tready <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else begin
        m_tready <= 1'b1;
        rx_stall <= pick_gap(rx_idle_on);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic push_access(logic [aht_pkg::CMD_W-1:0] cmd, logic [15:0] node);
    access_t a;
    a.cmd = cmd;
    a.node = node;
    accesses_pending.insert(accesses_pending.size(), a);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accesses_pending.size() != 0 || s_tvalid || hazards_expected.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_object(logic [15:0] id);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_we <= 1'b0;
    object_model = id;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_node();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom);
      default: return node_pool[$urandom_range(0, 3)];
    endcase
  endfunction

  task automatic queue_traffic(int count);
    int made;
    int run;
    made = 0;
    foreach (node_pool[i]) node_pool[i] = 16'($urandom);
    while (made < count) begin
      push_access(aht_pkg::CMD_WRITE, pick_node());
      made++;
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 6);
      if (run > count - made) run = count - made;
      repeat (run) begin
        if ($urandom_range(0, 9) == 0)
          push_access($urandom_range(0, 1) ? CMD_NONE : CMD_UNDEF, 16'($urandom));
        else
          push_access(aht_pkg::CMD_READ, pick_node());
        made++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_object(16'hFFFF);
    push_access(aht_pkg::CMD_READ, 16'h0005);
    push_access(aht_pkg::CMD_WRITE, 16'h0005);
    push_access(aht_pkg::CMD_READ, 16'hFFFF);
    push_access(aht_pkg::CMD_READ, 16'h0000);
    push_access(aht_pkg::CMD_WRITE, 16'hAAAA);
    push_access(CMD_NONE, 16'h5555);
    push_access(CMD_UNDEF, 16'h1234);
    push_access(aht_pkg::CMD_WRITE, 16'hAAAA);
    for (int i = 0; i < READER_SLOTS; i++)
      push_access(aht_pkg::CMD_READ, (i % 4 == 0) ? 16'hAAAA : 16'h0100 + 16'(i % 5));
    push_access(aht_pkg::CMD_READ, 16'h7777);
    push_access(aht_pkg::CMD_READ, 16'hAAAA);
    push_access(aht_pkg::CMD_WRITE, 16'h0F0F);
    wait_drained();

    set_object(16'h0000);
    queue_traffic(23);
    wait_drained();

    set_object(16'($urandom));
    hold_req = 1'b1;
    queue_traffic(23);
    wait_drained();

    set_object(16'($urandom));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    queue_traffic(23);
    wait_drained();

    set_object(16'hFFFF);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    queue_traffic(23);
    wait_drained();

    repeat (40) @(posedge clk);
    if (mismatches == 0 && hazards_expected.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
